// ===== src/lpkm_pkg.sv =====
package lpkm_pkg;

    localparam int CAPACITY_DEFAULT = 256;
    localparam int WORD_W = 64;

    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO_KEY = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== src/linear_probe_int_key_map_unit.sv =====
// Channel   Signals                                      Handshake
// request   func, hash_value, key_word, value_word       start high while busy low
// result    found, read_value, status                    done strobe, one cycle
//
// A request with a zero key returns in the cycle after it is taken.
// Any other request reads the probed slots in turn, one slot read per cycle from
// the single slot memory, and probes at most CAPACITY slots.
// After reset the slot memory is cleared one slot per cycle, with busy held high.
// The result cannot be held off; it is shown for exactly one cycle.
module linear_probe_int_key_map_unit #(
    parameter int CAPACITY = lpkm_pkg::CAPACITY_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [lpkm_pkg::WORD_W-1:0] hash_value,
    input  logic [lpkm_pkg::WORD_W-1:0] key_word,
    input  logic [lpkm_pkg::WORD_W-1:0] value_word,
    output logic                        done,
    output logic                        found,
    output logic [lpkm_pkg::WORD_W-1:0] read_value,
    output logic [1:0]                  status
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] HALF_CAP = AW'(CAPACITY / 2);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] probe_addr_reg, probe_addr_next;
    logic [AW-1:0] probe_cnt_reg, probe_cnt_next;
    logic [AW-1:0] count_reg, count_next;
    logic func_reg, func_next;
    logic [lpkm_pkg::WORD_W-1:0] hash_reg, hash_next;
    logic [lpkm_pkg::WORD_W-1:0] key_reg, key_next;
    logic [lpkm_pkg::WORD_W-1:0] value_reg, value_next;
    logic done_reg, done_next;
    logic found_reg, found_next;
    logic [lpkm_pkg::WORD_W-1:0] read_value_reg, read_value_next;
    logic [1:0] status_reg, status_next;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    lpkm_pkg::slot_t wr_slot;
    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic [lpkm_pkg::SLOT_W-1:0] rd_data;
    lpkm_pkg::slot_t rd_slot;
    logic slot_empty;
    logic slot_match;

    assign rd_slot = lpkm_pkg::slot_t'(rd_data);
    assign slot_empty = (rd_slot.key == '0);
    assign slot_match = (rd_slot.key == key_reg) && (rd_slot.hash == hash_reg);

    lpkm_ram #(
        .WIDTH(lpkm_pkg::SLOT_W),
        .DEPTH(CAPACITY)
    ) u_slot_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_slot),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_addr_next = clr_addr_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next = probe_cnt_reg;
        count_next = count_reg;
        func_next = func_reg;
        hash_next = hash_reg;
        key_next = key_reg;
        value_next = value_reg;
        done_next = 1'b0;
        found_next = found_reg;
        read_value_next = read_value_reg;
        status_next = status_reg;
        wr_en = 1'b0;
        wr_addr = probe_addr_reg;
        wr_slot = '0;
        rd_en = 1'b0;
        rd_addr = probe_addr_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    hash_next = hash_value;
                    key_next = key_word;
                    value_next = value_word;
                    probe_addr_next = hash_value[AW-1:0];
                    probe_cnt_next = '0;
                    if (key_word == '0)
                    begin
                        done_next = 1'b1;
                        found_next = 1'b0;
                        read_value_next = '0;
                        status_next = lpkm_pkg::ST_ZERO_KEY;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_en = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                found_next = 1'b0;
                read_value_next = '0;
                status_next = lpkm_pkg::ST_OK;
                if (slot_empty)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                    if (func_reg == lpkm_pkg::FUNC_SET)
                    begin
                        if (count_reg >= HALF_CAP)
                        begin
                            status_next = lpkm_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            wr_slot.key = key_reg;
                            wr_slot.hash = hash_reg;
                            wr_slot.value = value_reg;
                            count_next = count_reg + AW'(1);
                        end
                    end
                end
                else if (slot_match)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                    found_next = 1'b1;
                    if (func_reg == lpkm_pkg::FUNC_GET)
                    begin
                        read_value_next = rd_slot.value;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        wr_slot.key = (value_reg == '0) ? '0 : rd_slot.key;
                        wr_slot.hash = rd_slot.hash;
                        wr_slot.value = value_reg;
                    end
                end
                else if (probe_cnt_reg == '1)
                begin
                    // Every slot was visited without a match or a free slot.
                    done_next = 1'b1;
                    state_next = S_IDLE;
                    if (func_reg == lpkm_pkg::FUNC_SET)
                    begin
                        status_next = lpkm_pkg::ST_FULL;
                    end
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = probe_addr_reg + AW'(1);
                    probe_addr_next = probe_addr_reg + AW'(1);
                    probe_cnt_next = probe_cnt_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_addr_reg <= '0;
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg <= count_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg <= probe_cnt_next;
        func_reg <= func_next;
        hash_reg <= hash_next;
        key_reg <= key_next;
        value_reg <= value_next;
        found_reg <= found_next;
        read_value_reg <= read_value_next;
        status_reg <= status_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign found = found_reg;
    assign read_value = read_value_reg;
    assign status = status_reg;

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done_reg)
        else $error("result strobe during clearing pass");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= HALF_CAP)
        else $error("entry count above half capacity");

    a_zero_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key_word == '0) |=> (done_reg && status_reg == lpkm_pkg::ST_ZERO_KEY))
        else $error("zero key request not answered next cycle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (status_reg == lpkm_pkg::ST_OK))
        else $error("hit reported with error status");

endmodule

// ===== src/lpkm_ram.sv =====
module lpkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int CAP = lpkm_pkg::CAPACITY_DEFAULT;
    localparam int WORD_W = lpkm_pkg::WORD_W;
    localparam int SLOT_BITS = $clog2(CAP);
    localparam int RANDOM_REQUESTS = 1100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef struct {
        logic              func;
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
        int unsigned       gap;
    } map_request_t;

    typedef struct {
        logic              found;
        logic [WORD_W-1:0] read_value;
        logic [1:0]        status;
    } map_result_t;

    typedef struct {
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] key;
    } key_pair_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              func = lpkm_pkg::FUNC_SET;
    logic [WORD_W-1:0] hash_value = '0;
    logic [WORD_W-1:0] key_word = '0;
    logic [WORD_W-1:0] value_word = '0;
    logic              busy;
    logic              done;
    logic              found;
    logic [WORD_W-1:0] read_value;
    logic [1:0]        status;

    map_request_t request_queue[$];
    map_result_t  expected_results[$];
    key_pair_t    known_pairs[$];

    bit [WORD_W-1:0] table_key [CAP];
    bit [WORD_W-1:0] table_hash [CAP];
    bit [WORD_W-1:0] table_value [CAP];
    int unsigned     table_inserts = 0;

    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned gap_count = 0;
    bit          req_taken = 1'b0;
    bit          quiet_stretch = 1'b0;
    map_request_t next_req;
    map_result_t  got_result;
    map_result_t  want_result;

    linear_probe_int_key_map_unit #(
        .CAPACITY(CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .hash_value(hash_value),
        .key_word(key_word),
        .value_word(value_word),
        .done(done),
        .found(found),
        .read_value(read_value),
        .status(status)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic note_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // Updates the table copy with one request and returns the result it must produce.
    function automatic map_result_t apply_map_request(input map_request_t req);
        map_result_t res;
        int unsigned slot;
        int unsigned n;
        bit          hit;
        bit          hole;
        res = '{1'b0, '0, lpkm_pkg::ST_OK};
        if (req.key == '0)
        begin
            res.status = lpkm_pkg::ST_ZERO_KEY;
            return res;
        end
        slot = 32'(req.hash[SLOT_BITS-1:0]);
        hit = 1'b0;
        hole = 1'b0;
        for (n = 0; n < CAP && !hit && !hole; n++)
        begin
            if (table_key[slot] == '0)
                hole = 1'b1;
            else if (table_hash[slot] == req.hash && table_key[slot] == req.key)
                hit = 1'b1;
            else
                slot = (slot + 1) % CAP;
        end
        if (req.func == lpkm_pkg::FUNC_GET)
        begin
            if (hit)
            begin
                res.found = 1'b1;
                res.read_value = table_value[slot];
            end
        end
        else if (hit)
        begin
            res.found = 1'b1;
            table_value[slot] = req.value;
            if (req.value == '0)
                table_key[slot] = '0;
        end
        else if (table_inserts >= CAP / 2 || !hole)
        begin
            res.status = lpkm_pkg::ST_FULL;
        end
        else
        begin
            table_key[slot] = req.key;
            table_hash[slot] = req.hash;
            table_value[slot] = req.value;
            table_inserts++;
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Half of the hashes land in a narrow window around the wrap point to build long chains.
    function automatic logic [WORD_W-1:0] random_hash();
        logic [WORD_W-1:0] h;
        h = random_word();
        if ($urandom_range(0, 1) == 0)
            h[SLOT_BITS-1:0] = SLOT_BITS'(CAP - 6 + $urandom_range(0, 11));
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return ALL_ONES;
            1: return WORD_W'($urandom_range(1, 15));
            default: return random_word();
        endcase
    endfunction

    task automatic add_request(input logic op, input logic [WORD_W-1:0] h,
                               input logic [WORD_W-1:0] k, input logic [WORD_W-1:0] v);
        map_request_t req;
        if ($urandom_range(0, 39) == 0)
            quiet_stretch = ($urandom_range(0, 2) == 0);
        req.func = op;
        req.hash = h;
        req.key = k;
        req.value = v;
        req.gap = quiet_stretch ? 0 : $urandom_range(0, 7);
        request_queue.push_back(req);
    endtask

    task automatic add_random_request();
        key_pair_t   pair;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (known_pairs.size() != 0)
            pair = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
        if (pick < 6)
        begin
            add_request(1'($urandom_range(0, 1)), random_word(), '0, random_value());
        end
        else if (pick < 16 || known_pairs.size() == 0)
        begin
            case ($urandom_range(0, 3))
                0: pair.hash = random_hash();
                1: pair.key = random_word() | 64'h1;
                default:
                begin
                    pair.hash = random_hash();
                    pair.key = random_word() | 64'h1;
                end
            endcase
            if ($urandom_range(0, 1) == 0)
                pair.key = ~random_word() | (64'h1 << $urandom_range(0, 63));
            known_pairs.push_back(pair);
            add_request(lpkm_pkg::FUNC_SET, pair.hash, pair.key,
                        ($urandom_range(0, 9) == 0) ? '0 : random_value());
        end
        else if (pick < 46)
        begin
            add_request(lpkm_pkg::FUNC_GET, pair.hash, pair.key, random_word());
        end
        else if (pick < 76)
        begin
            add_request(lpkm_pkg::FUNC_SET, pair.hash, pair.key, random_value());
        end
        else if (pick < 86)
        begin
            add_request(lpkm_pkg::FUNC_SET, pair.hash, pair.key, '0);
        end
        else if (pick < 97)
        begin
            add_request(lpkm_pkg::FUNC_GET, random_hash(), random_word() | 64'h1,
                        random_value());
        end
        else
        begin
            add_request(lpkm_pkg::FUNC_SET, random_hash(), random_word() | 64'h1,
                        random_value());
        end
    endtask

    initial
    begin
        add_request(lpkm_pkg::FUNC_GET, '0, 64'h1, '0);
        add_request(lpkm_pkg::FUNC_SET, ALL_ONES, '0, ALL_ONES);
        add_request(lpkm_pkg::FUNC_GET, '0, '0, '0);
        add_request(lpkm_pkg::FUNC_SET, ALL_ONES, ALL_ONES, ALL_ONES);
        add_request(lpkm_pkg::FUNC_GET, ALL_ONES, ALL_ONES, '0);
        // Same key under another hash with the same start slot wraps to slot zero.
        add_request(lpkm_pkg::FUNC_SET, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES, 64'h1);
        // A missing key is inserted even when its value is zero.
        add_request(lpkm_pkg::FUNC_SET, ALL_ONES, 64'h8000_0000_0000_0000, '0);
        add_request(lpkm_pkg::FUNC_GET, ALL_ONES, 64'h8000_0000_0000_0000, ALL_ONES);
        add_request(lpkm_pkg::FUNC_SET, ALL_ONES, ALL_ONES, 64'h0123_4567_89AB_CDEF);
        add_request(lpkm_pkg::FUNC_GET, ALL_ONES, ALL_ONES, '0);
        add_request(lpkm_pkg::FUNC_GET, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES, '0);
        // Deleting the head of the chain hides the entries placed behind it.
        add_request(lpkm_pkg::FUNC_SET, ALL_ONES, ALL_ONES, '0);
        add_request(lpkm_pkg::FUNC_GET, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES, '0);
        add_request(lpkm_pkg::FUNC_GET, ALL_ONES, ALL_ONES, '0);
        add_request(lpkm_pkg::FUNC_SET, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES,
                    64'hAAAA_AAAA_AAAA_AAAA);
        add_request(lpkm_pkg::FUNC_SET, '0, 64'h1, 64'h5555_5555_5555_5555);
        add_request(lpkm_pkg::FUNC_GET, '0, 64'h1, '0);
        add_request(lpkm_pkg::FUNC_GET, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES, '0);
        add_request(lpkm_pkg::FUNC_SET, '0, '0, '0);
        known_pairs.push_back('{ALL_ONES, ALL_ONES});
        known_pairs.push_back('{64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES});
        known_pairs.push_back('{ALL_ONES, 64'h8000_0000_0000_0000});
        known_pairs.push_back('{64'h0, 64'h1});
        repeat (RANDOM_REQUESTS) add_random_request();

        while (request_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !req_taken)
        begin
        end
        else if (request_queue.size() != 0 && gap_count >= request_queue[0].gap)
        begin
            next_req = request_queue.pop_front();
            func <= next_req.func;
            hash_value <= next_req.hash;
            key_word <= next_req.key;
            value_word <= next_req.value;
            start <= 1'b1;
            gap_count = 0;
        end
        else
        begin
            start <= 1'b0;
            if (request_queue.size() != 0)
                gap_count++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                got_result = '{found, read_value, status};
                if (expected_results.size() == 0)
                begin
                    note_mismatch($sformatf(
                        "result with no request outstanding: found %b value %h status %0d",
                        found, read_value, status));
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.found !== want_result.found)
                        note_mismatch($sformatf("found: got %b expected %b",
                                                got_result.found, want_result.found));
                    if (got_result.read_value !== want_result.read_value)
                        note_mismatch($sformatf("read_value: got %h expected %h",
                                                got_result.read_value, want_result.read_value));
                    if (got_result.status !== want_result.status)
                        note_mismatch($sformatf("status: got %0d expected %0d",
                                                got_result.status, want_result.status));
                end
            end
            req_taken = start && !busy;
            if (req_taken)
                expected_results.push_back(apply_map_request('{func, hash_value, key_word,
                                                               value_word, 0}));
            if (done || req_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

// ===== linear_probe_int_key_map_unit.f =====
src/lpkm_pkg.sv
src/lpkm_ram.sv
src/linear_probe_int_key_map_unit.sv
dv/tb.sv
